>>> sv/mp2_pkg.sv
// Package for the 2x2 matrix power block: widths, matrix types,
// controller state and the command/status structs between controller and datapath.
// No dependencies.
package mp2_pkg;

  localparam int DATA_W              = 32;
  localparam int EXP_W               = 31;
  localparam int DIM_MAX             = 2;
  localparam int MATRIX_SIZE_DEFAULT = 2;
  localparam int IN_W                = 4 * DATA_W + EXP_W;
  localparam int IN_BYTES_W          = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W               = 4 * DATA_W;

  typedef logic [DATA_W-1:0] word_t;

  // Index order: [row][col].
  typedef logic [DIM_MAX-1:0][DIM_MAX-1:0][DATA_W-1:0] mat_t;

  // Partial products for one matrix multiply: [row][col][k].
  typedef logic [DIM_MAX-1:0][DIM_MAX-1:0][DIM_MAX-1:0][DATA_W-1:0] prod_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;      // take a new matrix and exponent
    logic mul;       // register the partial products
    logic sum;       // fold the products into acc and base, shift exponent
    logic out_load;  // copy acc into the output register
  } cmd_t;

  typedef struct packed {
    logic exp_zero;  // no exponent bits left
  } status_t;

  // Low half of a 32x32 product; wraps modulo 2^32.
  function automatic word_t mul_lo(input word_t a, input word_t b);
    logic [2*DATA_W-1:0] full;
    full = a * b;
    return full[DATA_W-1:0];
  endfunction

endpackage

>>> sv/mp2_ctrl.sv
// Controller for the 2x2 matrix power block: sequences load, multiply, sum
// and output steps, and owns the handshake state. Depends on mp2_pkg.
module mp2_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  mp2_pkg::status_t status,
  output mp2_pkg::cmd_t    cmd
);

  mp2_pkg::state_t state, state_next;
  logic            m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mp2_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_tready      = 1'b0;
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      mp2_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = mp2_pkg::ST_MUL;
        end
      end
      mp2_pkg::ST_MUL: begin
        if (status.exp_zero) begin
          state_next = mp2_pkg::ST_FIN;
        end else begin
          cmd.mul    = 1'b1;
          state_next = mp2_pkg::ST_SUM;
        end
      end
      mp2_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = mp2_pkg::ST_MUL;
      end
      mp2_pkg::ST_FIN: begin
        // Hold until the output register is free or drains this cycle.
        if (!m_tvalid || m_tready) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = mp2_pkg::ST_IDLE;
        end
      end
      default: state_next = mp2_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> sv/mp2_dp.sv
// Datapath for the 2x2 matrix power block: base, accumulator, exponent,
// two banks of partial-product registers and the output register. Depends on mp2_pkg.
module mp2_dp #(
  parameter int MATRIX_SIZE = mp2_pkg::MATRIX_SIZE_DEFAULT
) (
  input  logic                      clk,
  input  mp2_pkg::cmd_t             cmd,
  input  mp2_pkg::mat_t             a_in,
  input  logic [mp2_pkg::EXP_W-1:0] exp_in,
  output mp2_pkg::status_t          status,
  output mp2_pkg::mat_t             r_out
);

  mp2_pkg::mat_t             base;
  mp2_pkg::mat_t             acc;
  logic [mp2_pkg::EXP_W-1:0] expo;
  mp2_pkg::prod_t            prod_acc;
  mp2_pkg::prod_t            prod_sq;

  mp2_pkg::mat_t  base_load, acc_load, base_sum, acc_sum;
  mp2_pkg::prod_t prod_acc_next, prod_sq_next;

  // Entries outside the active size are held at zero so they drop out of every product.
  always_comb begin
    for (int i = 0; i < mp2_pkg::DIM_MAX; i++) begin
      for (int j = 0; j < mp2_pkg::DIM_MAX; j++) begin
        if (i < MATRIX_SIZE && j < MATRIX_SIZE) begin
          base_load[i][j] = a_in[i][j];
        end else begin
          base_load[i][j] = '0;
        end
        if (i == j && i < MATRIX_SIZE) begin
          acc_load[i][j] = mp2_pkg::word_t'(1);
        end else begin
          acc_load[i][j] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < mp2_pkg::DIM_MAX; i++) begin
      for (int j = 0; j < mp2_pkg::DIM_MAX; j++) begin
        for (int k = 0; k < mp2_pkg::DIM_MAX; k++) begin
          prod_acc_next[i][j][k] = mp2_pkg::mul_lo(acc[i][k], base[k][j]);
          prod_sq_next[i][j][k]  = mp2_pkg::mul_lo(base[i][k], base[k][j]);
        end
        acc_sum[i][j]  = prod_acc[i][j][0] + prod_acc[i][j][1];
        base_sum[i][j] = prod_sq[i][j][0] + prod_sq[i][j][1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= base_load;
      acc  <= acc_load;
      expo <= exp_in;
    end else if (cmd.sum) begin
      base <= base_sum;
      if (expo[0]) begin
        acc <= acc_sum;
      end
      expo <= expo >> 1;
    end
    if (cmd.mul) begin
      prod_acc <= prod_acc_next;
      prod_sq  <= prod_sq_next;
    end
    if (cmd.out_load) begin
      r_out <= acc;
    end
  end

  assign status.exp_zero = (expo == '0);

endmodule

>>> sv/matrix_power_2x2.sv
// Top level of the 2x2 matrix power block: stream ports, field packing,
// controller and datapath. Depends on mp2_pkg, mp2_ctrl and mp2_dp.
//
// Raises a 2x2 matrix of 32-bit two's complement entries to a 31-bit
// unsigned power by square-and-multiply from the least significant exponent
// bit, all arithmetic wrapping modulo 2^32; an exponent of zero returns the
// identity. One item is in flight at a time. The next item is taken in the
// cycle after the result is written to the output register. If the previous
// result is still waiting on m_tready, hold the finished item until that beat
// drains. Each exponent bit takes a multiply step and then a sum step: the
// multiply step registers sixteen 32-bit partial products (acc*base and
// base*base at once), the sum step adds them up into the new running power
// and, when the exponent bit is one, into the new accumulator.
// The output register holds a finished result while a new item is accepted
// and worked on. MATRIX_SIZE = 1 reduces the block to a scalar power in r00
// with r01, r10 and r11 held at zero.
module matrix_power_2x2 #(
  parameter int MATRIX_SIZE = mp2_pkg::MATRIX_SIZE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // a00 [31:0], a01 [63:32], a10 [95:64], a11 [127:96], exponent [158:128], zero pad [159]
  input  logic [mp2_pkg::IN_BYTES_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // r00 [31:0], r01 [63:32], r10 [95:64], r11 [127:96]
  output logic [mp2_pkg::OUT_W-1:0]      m_tdata
);

  localparam int W = mp2_pkg::DATA_W;

  mp2_pkg::cmd_t             cmd;
  mp2_pkg::status_t          status;
  mp2_pkg::mat_t             a_in;
  mp2_pkg::mat_t             r_out;
  logic [mp2_pkg::EXP_W-1:0] exp_in;

  // Unpack the input beat; the pad bit above the exponent is dropped.
  assign a_in[0][0] = s_tdata[0*W +: W];
  assign a_in[0][1] = s_tdata[1*W +: W];
  assign a_in[1][0] = s_tdata[2*W +: W];
  assign a_in[1][1] = s_tdata[3*W +: W];
  assign exp_in     = s_tdata[4*W +: mp2_pkg::EXP_W];

  assign m_tdata = {r_out[1][1], r_out[1][0], r_out[0][1], r_out[0][0]};

  mp2_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mp2_dp #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .a_in   (a_in),
    .exp_in (exp_in),
    .status (status),
    .r_out  (r_out)
  );

endmodule

>>> bench/tb_matrix_power_2x2.sv
// Self-checking bench for matrix_power_2x2: random and directed 2x2 matrix powers
// against a square-and-multiply predictor, with idle/stall phases and a long hold-off.
// Depends on mp2_pkg and matrix_power_2x2.
module tb_matrix_power_2x2;
  timeunit 1ns;
  timeprecision 1ps;

  import mp2_pkg::*;

  // Matrix dimension under test, and the dimension the arithmetic really uses
  // (above the maximum acts as the maximum, below one drops everything to zero).
  localparam int DIM        = MATRIX_SIZE_DEFAULT;
  localparam int ACTIVE_DIM = (DIM < 1) ? 0 : ((DIM > DIM_MAX) ? DIM_MAX : DIM);

  localparam int  CYCLE_LIMIT    = 400000;
  localparam int  HOLDOFF_CYCLES = 300;
  localparam int  TAIL_CYCLES    = 80;
  localparam int  PHASE_ITEMS    = 220;
  localparam int  HOLD_ITEMS     = 12;

  localparam word_t W_MAX = 32'h7FFF_FFFF;
  localparam word_t W_MIN = 32'h8000_0000;
  localparam word_t W_M1  = 32'hFFFF_FFFF;
  localparam logic [EXP_W-1:0] EXP_MAX = '1;

  typedef struct {
    word_t            a00;
    word_t            a01;
    word_t            a10;
    word_t            a11;
    logic [EXP_W-1:0] exponent;
  } mat_item_t;

  typedef struct {
    word_t r00;
    word_t r01;
    word_t r10;
    word_t r11;
  } power_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_BYTES_W-1:0] s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;

  mat_item_t     pending_q[$];   // matrices waiting to be offered
  power_result_t powers_q[$];    // predicted powers, oldest first
  mat_item_t     tx_item;        // matrix currently on s_tdata
  power_result_t rx_power;
  power_result_t want_power;
  logic          offer;

  int  send_idle_pct;
  int  recv_stall_pct;
  logic rx_hold;
  logic holdoff_go;
  int  errors;
  int  cycle_cnt;

  matrix_power_2x2 #(
    .MATRIX_SIZE(DIM)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Product of two matrices over the active size; every sum and product wraps.
  function automatic mat_t mat_product(input mat_t x, input mat_t y);
    mat_t  p;
    word_t sum;
    p = '0;
    for (int i = 0; i < ACTIVE_DIM; i++) begin
      for (int j = 0; j < ACTIVE_DIM; j++) begin
        sum = '0;
        for (int k = 0; k < ACTIVE_DIM; k++) begin
          sum = sum + x[i][k] * y[k][j];
        end
        p[i][j] = sum;
      end
    end
    return p;
  endfunction

  // Start from the identity, scan the exponent from its low bit: fold the running
  // power into the accumulator on a one, then square the running power.
  function automatic power_result_t predict_power(input mat_item_t it);
    mat_t             acc;
    mat_t             base;
    logic [EXP_W-1:0] e;
    power_result_t    r;
    base = '0;
    base[0][0] = it.a00;
    base[0][1] = it.a01;
    base[1][0] = it.a10;
    base[1][1] = it.a11;
    acc = '0;
    for (int i = 0; i < ACTIVE_DIM; i++) begin
      acc[i][i] = 32'd1;
    end
    e = it.exponent;
    while (e != '0) begin
      if (e[0]) begin
        acc = mat_product(acc, base);
      end
      base = mat_product(base, base);
      e = e >> 1;
    end
    r.r00 = acc[0][0];
    r.r01 = acc[0][1];
    r.r10 = acc[1][0];
    r.r11 = acc[1][1];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic mat_item_t mk_item(input word_t a00, input word_t a01, input word_t a10,
                                        input word_t a11, input logic [EXP_W-1:0] exponent);
    mat_item_t it;
    it.a00      = a00;
    it.a01      = a01;
    it.a10      = a10;
    it.a11      = a11;
    it.exponent = exponent;
    return it;
  endfunction

  // Mostly full-range words, with small signed values and the corner words mixed in
  // so that powers stay nonzero and exact for a while before wrapping.
  function automatic word_t rand_entry();
    word_t w;
    case ($urandom_range(0, 9))
      0, 1: begin
        w = word_t'($urandom_range(0, 16)) - 32'd8;
      end
      2: begin
        case ($urandom_range(0, 4))
          0: w = '0;
          1: w = 32'd1;
          2: w = W_M1;
          3: w = W_MAX;
          default: w = W_MIN;
        endcase
      end
      default: begin
        w = $urandom;
      end
    endcase
    return w;
  endfunction

  // Pick a bit length, then a random value of exactly that length, so short and
  // long square-and-multiply runs are equally common.
  function automatic logic [EXP_W-1:0] rand_exponent();
    int          len;
    logic [31:0] e;
    len = $urandom_range(0, EXP_W);
    e   = $urandom;
    if (len == 0) begin
      e = '0;
    end else begin
      e = e & ((32'd1 << len) - 32'd1);
      e[len-1] = 1'b1;
    end
    return e[EXP_W-1:0];
  endfunction

  function automatic mat_item_t rand_item();
    return mk_item(rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_exponent());
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued matrices, predict the power of each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      // Record the beat that the block took at this edge.
      if (s_tvalid && s_tready) begin
        powers_q.push_back(predict_power(tx_item));
      end
      // Advance only when the line is free or the current beat just went through;
      // otherwise hold the beat steady.
      if (!s_tvalid || s_tready) begin
        offer = 1'b0;
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          tx_item = pending_q.pop_front();
          s_tdata <= {{(IN_BYTES_W - IN_W){1'b0}}, tx_item.exponent,
                      tx_item.a11, tx_item.a10, tx_item.a01, tx_item.a00};
          offer = 1'b1;
        end
        s_tvalid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        rx_power.r00 = m_tdata[31:0];
        rx_power.r01 = m_tdata[63:32];
        rx_power.r10 = m_tdata[95:64];
        rx_power.r11 = m_tdata[127:96];
        if (powers_q.size() == 0) begin
          $error("result beat with no prediction waiting: r00=%0d r01=%0d r10=%0d r11=%0d",
                 $signed(rx_power.r00), $signed(rx_power.r01),
                 $signed(rx_power.r10), $signed(rx_power.r11));
          errors++;
        end else begin
          want_power = powers_q.pop_front();
          check_field("r00", want_power.r00, rx_power.r00);
          check_field("r01", want_power.r01, rx_power.r01);
          check_field("r10", want_power.r10, rx_power.r10);
          check_field("r11", want_power.r11, rx_power.r11);
        end
      end
      // Drop ready at random, and hard during the long hold-off.
      m_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile
  // and the block fills up and stalls its input.
  initial begin
    rx_hold = 1'b0;
    wait (holdoff_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: reset, directed set, hold-off, then the random phases
  // ---------------------------------------------------------------------------

  // Wait at falling edges until every queued beat went in and every power came out.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_q.size() != 0 || s_tvalid || powers_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_go     = 1'b0;
    errors         = 0;
    cycle_cnt      = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed set, no idling: zero exponent, zero matrix, identity, wrap-around
    // growth, corner words, single-bit and alternating exponents.
    pending_q.push_back(mk_item($urandom, $urandom, $urandom, $urandom, '0));
    pending_q.push_back(mk_item('0, '0, '0, '0, '0));
    pending_q.push_back(mk_item('0, '0, '0, '0, 31'd5));
    pending_q.push_back(mk_item(32'd1, '0, '0, 32'd1, EXP_MAX));
    pending_q.push_back(mk_item(32'd1, 32'd1, 32'd1, '0, 31'd10));
    pending_q.push_back(mk_item(32'd1, 32'd1, 32'd1, '0, 31'd47));
    pending_q.push_back(mk_item(32'd1, 32'd1, 32'd1, '0, EXP_MAX));
    pending_q.push_back(mk_item(W_MAX, W_MAX, W_MAX, W_MAX, 31'd1));
    pending_q.push_back(mk_item(W_MAX, W_MAX, W_MAX, W_MAX, 31'd2));
    pending_q.push_back(mk_item(W_MIN, W_MIN, W_MIN, W_MIN, 31'd1));
    pending_q.push_back(mk_item(W_MIN, W_MIN, W_MIN, W_MIN, 31'd3));
    pending_q.push_back(mk_item(W_M1, W_M1, W_M1, W_M1, 31'd1));
    pending_q.push_back(mk_item(W_M1, W_M1, W_M1, W_M1, 31'd3));
    pending_q.push_back(mk_item(W_MAX, W_MIN, W_MIN, W_MAX, EXP_MAX));
    pending_q.push_back(mk_item(32'd2, '0, '0, 32'd3, 31'd30));
    pending_q.push_back(mk_item(32'd2, '0, '0, 32'd3, 31'd31));
    pending_q.push_back(mk_item('0, 32'd1, W_M1, '0, 31'd4));
    pending_q.push_back(mk_item('0, 32'd1, W_M1, '0, EXP_MAX));
    pending_q.push_back(mk_item($urandom, $urandom, $urandom, $urandom, 31'd1));
    pending_q.push_back(mk_item($urandom, $urandom, $urandom, $urandom, 31'h4000_0000));
    pending_q.push_back(mk_item($urandom, $urandom, $urandom, $urandom, 31'h5555_5555));
    pending_q.push_back(mk_item($urandom, $urandom, $urandom, $urandom, 31'h2AAA_AAAA));
    wait_drained();

    // Back pressure: queue a burst and hold the receiver off for a long stretch.
    for (int n = 0; n < HOLD_ITEMS; n++) begin
      pending_q.push_back(rand_item());
    end
    holdoff_go = 1'b1;
    wait_drained();

    // Random phases; the sender pauses at each boundary until every power is back.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pending_q.push_back(rand_item());
      end
      wait_drained();
    end

    // Let any stray beat show up before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (powers_q.size() != 0) begin
      $error("%0d predicted powers never arrived", powers_q.size());
      errors++;
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
